>>> rtl/lzd_pkg.sv
package lzd_pkg;

    localparam int WINDOW_BYTES = 8192;
    localparam int WIN_BITS = 13;
    localparam int QUEUE_DEPTH = 2;

    // Parser phases.
    localparam logic [2:0] PH_FLAG_LO  = 3'd0;
    localparam logic [2:0] PH_FLAG_HI  = 3'd1;
    localparam logic [2:0] PH_LIT      = 3'd3;
    localparam logic [2:0] PH_SHORT    = 3'd4;
    localparam logic [2:0] PH_LONG_LO  = 3'd5;
    localparam logic [2:0] PH_LONG_HI  = 3'd6;
    localparam logic [2:0] PH_LONG_LEN = 3'd7;

    // Command kinds passed from the parser to the executor.
    localparam logic [1:0] CMD_LIT  = 2'd0;
    localparam logic [1:0] CMD_COPY = 2'd1;
    localparam logic [1:0] CMD_END  = 2'd2;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       start_req;
    } lzd_in_t;

    typedef struct packed {
        logic [7:0] out_byte0;
        logic [7:0] out_byte1;
        logic [7:0] out_byte2;
        logic [7:0] out_byte3;
        logic [2:0] byte_count;
        logic       last;
        logic       end_of_data;
        logic       status;
    } lzd_out_t;

    // One decoded command: literal, copy or end marker.
    typedef struct packed {
        logic [1:0]          kind;
        logic                restart;
        logic [7:0]          lit;
        logic [WIN_BITS-1:0] offset;
        logic [8:0]          len;
    } lzd_cmd_t;

endpackage

>>> rtl/lzd_parser.sv
module lzd_parser (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_stall,
    input  lzd_pkg::lzd_in_t in_data,
    output logic             cmd_valid,
    input  logic             cmd_stall,
    output lzd_pkg::lzd_cmd_t cmd_data
);
    import lzd_pkg::*;

    logic [2:0]          phase_reg, phase_next;
    logic [2:0]          prog_reg, prog_next;
    logic [15:0]         flags_reg, flags_next;
    logic [4:0]          left_reg, left_next;
    logic [WIN_BITS-1:0] dist_reg, dist_next;
    logic [8:0]          len_reg, len_next;
    logic                ended_reg, ended_next;
    logic                restart_reg, restart_next;
    logic                emit;
    lzd_cmd_t            cmd;
    logic                finish;
    logic                adv;
    logic [7:0]          b;

    // A decoded command is pushed into the queue as the byte is accepted.
    assign in_stall  = cmd_stall;
    assign cmd_valid = in_valid && emit;
    assign cmd_data  = cmd;
    assign b = in_data.in_byte;

    // Decode one byte and then consume flag bits until a byte is needed.
    always_comb
    begin
        logic [2:0]  ph;
        logic [2:0]  tp;
        logic [15:0] fl;
        logic [4:0]  lf;
        logic [8:0]  ln;
        logic [WIN_BITS-1:0] ds;
        logic        en;
        logic        rs;
        logic        bit0;
        ph = phase_reg;
        tp = prog_reg;
        fl = flags_reg;
        lf = left_reg;
        ln = len_reg;
        ds = dist_reg;
        en = ended_reg;
        rs = restart_reg;
        bit0 = 1'b0;
        emit = 1'b0;
        finish = 1'b0;
        adv = 1'b0;
        cmd = '0;
        if (in_data.start_req)
        begin
            ph = PH_FLAG_LO;
            tp = 3'd0;
            fl = '0;
            lf = '0;
            ln = '0;
            ds = '0;
            en = 1'b0;
            rs = 1'b1;
        end
        if (!en)
        begin
            unique case (ph)
                PH_FLAG_LO:
                begin
                    fl = {8'd0, b};
                    ph = PH_FLAG_HI;
                end
                PH_FLAG_HI:
                begin
                    fl = {b, fl[7:0]};
                    lf = 5'd16;
                    adv = 1'b1;
                end
                PH_LIT:
                begin
                    emit = 1'b1;
                    cmd.kind = CMD_LIT;
                    cmd.lit = b;
                    finish = 1'b1;
                end
                PH_SHORT:
                begin
                    ds = {5'h1f, b};
                    emit = 1'b1;
                    cmd.kind = CMD_COPY;
                    cmd.offset = ds;
                    cmd.len = ln;
                    finish = 1'b1;
                end
                PH_LONG_LO:
                begin
                    ds = {5'd0, b};
                    ph = PH_LONG_HI;
                end
                PH_LONG_HI:
                begin
                    ds = {b[7:3], ds[7:0]};
                    ln = {6'd0, b[2:0]} + 9'd2;
                    if (b[2:0] == 3'd0)
                        ph = PH_LONG_LEN;
                    else
                    begin
                        emit = 1'b1;
                        cmd.kind = CMD_COPY;
                        cmd.offset = ds;
                        cmd.len = ln;
                        finish = 1'b1;
                    end
                end
                PH_LONG_LEN:
                begin
                    priority if (b == 8'd0)
                    begin
                        en = 1'b1;
                        emit = 1'b1;
                        cmd.kind = CMD_END;
                    end
                    else if (b == 8'd1)
                        finish = 1'b1;
                    else
                    begin
                        ln = {1'b0, b} + 9'd1;
                        emit = 1'b1;
                        cmd.kind = CMD_COPY;
                        cmd.offset = ds;
                        cmd.len = ln;
                        finish = 1'b1;
                    end
                end
                default:
                    adv = 1'b1;
            endcase
            if (finish)
            begin
                tp = 3'd0;
                adv = 1'b1;
            end
            // Up to four flag bits are taken per token start.
            if (adv)
            begin
                for (int i = 0; i < 4; i++)
                begin
                    if (lf != 5'd0 && tp < 3'd4)
                    begin
                        bit0 = fl[0];
                        fl = {1'b0, fl[15:1]};
                        lf = lf - 5'd1;
                        unique case (tp)
                            3'd0: tp = bit0 ? 3'd4 : 3'd1;
                            3'd1: tp = bit0 ? 3'd6 : 3'd2;
                            3'd2:
                            begin
                                ln = {7'd0, bit0, 1'b0};
                                tp = 3'd3;
                            end
                            default:
                            begin
                                ln = (ln | {8'd0, bit0}) + 9'd2;
                                tp = 3'd5;
                            end
                        endcase
                    end
                end
                if (lf == 5'd0)
                    ph = PH_FLAG_LO;
                else if (tp == 3'd4)
                    ph = PH_LIT;
                else if (tp == 3'd5)
                    ph = PH_SHORT;
                else
                    ph = PH_LONG_LO;
            end
        end
        cmd.restart = rs;
        if (emit)
            rs = 1'b0;
        phase_next = ph;
        prog_next = tp;
        flags_next = fl;
        left_next = lf;
        len_next = ln;
        dist_next = ds;
        ended_next = en;
        restart_next = rs;
    end

    // Parser state advances on each accepted byte.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_FLAG_LO;
            prog_reg <= '0;
            flags_reg <= '0;
            left_reg <= '0;
            dist_reg <= '0;
            len_reg <= '0;
            ended_reg <= 1'b0;
            restart_reg <= 1'b1;
        end
        else if (in_valid && !in_stall)
        begin
            phase_reg <= phase_next;
            prog_reg <= prog_next;
            flags_reg <= flags_next;
            left_reg <= left_next;
            dist_reg <= dist_next;
            len_reg <= len_next;
            ended_reg <= ended_next;
            restart_reg <= restart_next;
        end
    end

endmodule

>>> rtl/lzd_queue.sv
module lzd_queue (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              wr_valid,
    output logic              wr_stall,
    input  lzd_pkg::lzd_cmd_t wr_data,
    output logic              rd_valid,
    input  logic              rd_take,
    output lzd_pkg::lzd_cmd_t rd_data
);
    import lzd_pkg::*;

    lzd_cmd_t   slot_reg [QUEUE_DEPTH];
    logic       wp_reg, rp_reg;
    logic [1:0] cnt_reg;

    assign wr_stall = (cnt_reg == 2'(QUEUE_DEPTH));
    assign rd_valid = (cnt_reg != 2'd0);
    assign rd_data  = slot_reg[rp_reg];

    // Two-entry command queue between parser and executor.
    always_ff @(posedge clk)
    begin
        if (wr_valid && !wr_stall)
            slot_reg[wp_reg] <= wr_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg <= 1'b0;
            rp_reg <= 1'b0;
            cnt_reg <= '0;
        end
        else
        begin
            if (wr_valid && !wr_stall)
                wp_reg <= ~wp_reg;
            if (rd_take)
                rp_reg <= ~rp_reg;
            cnt_reg <= cnt_reg + 2'(wr_valid && !wr_stall) - 2'(rd_take);
        end
    end

endmodule

>>> rtl/lzd_exec.sv
module lzd_exec (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cmd_valid,
    output logic              cmd_take,
    input  lzd_pkg::lzd_cmd_t cmd_data,
    output logic              out_valid,
    input  logic              out_stall,
    output lzd_pkg::lzd_out_t out_data
);
    import lzd_pkg::*;

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_READ  = 2'd1;
    localparam logic [1:0] ST_WRITE = 2'd2;

    logic [7:0]          hist_mem [WINDOW_BYTES];
    logic [1:0]          state_reg;
    logic [WIN_BITS-1:0] wp_reg;
    logic [WIN_BITS:0]   prod_reg;
    logic [8:0]          rem_reg;
    logic [WIN_BITS-1:0] dist_reg;
    logic                err_reg;
    logic [1:0]          idx_reg;
    logic [31:0]         pack_reg;
    logic [7:0]          rd_reg;
    logic                ov_reg;
    lzd_out_t            od_reg;
    logic [WIN_BITS:0]   back;
    logic [WIN_BITS:0]   prod_eff;
    logic [7:0]          wbyte;
    logic                wen;
    logic                flush;
    logic                out_load;
    logic [WIN_BITS-1:0] wp_eff;

    assign out_valid = ov_reg;
    assign out_data  = od_reg;
    assign cmd_take  = (state_reg == ST_IDLE) && cmd_valid && !(ov_reg && out_stall);
    assign back = (WIN_BITS+1)'(WINDOW_BYTES) - {1'b0, cmd_data.offset};
    assign prod_eff = cmd_data.restart ? '0 : prod_reg;
    assign wp_eff = wp_reg;

    // Byte written to history and packed into the result.
    always_comb
    begin
        wbyte = err_reg ? 8'd0 : rd_reg;
        wen = (state_reg == ST_WRITE) && !(ov_reg && out_stall);
        flush = wen && (idx_reg == 2'd3 || rem_reg == 9'd1);
        out_load = (cmd_take && (cmd_data.kind == CMD_LIT || cmd_data.kind == CMD_END))
                   || flush;
    end

    // History read, one source byte per copy step.
    always_ff @(posedge clk)
    begin
        rd_reg <= hist_mem[wp_eff + dist_reg];
        if (cmd_take && cmd_data.kind == CMD_LIT)
            hist_mem[cmd_data.restart ? 13'd0 : wp_reg] <= cmd_data.lit;
        else if (wen)
            hist_mem[wp_reg] <= wbyte;
    end

    // Sequencer: literals and end markers finish at once, copies alternate read and write.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            wp_reg <= '0;
            prod_reg <= '0;
            rem_reg <= '0;
            dist_reg <= '0;
            err_reg <= 1'b0;
            idx_reg <= '0;
            pack_reg <= '0;
            ov_reg <= 1'b0;
            od_reg <= '0;
        end
        else
        begin
            if (out_load)
                ov_reg <= 1'b1;
            else if (ov_reg && !out_stall)
                ov_reg <= 1'b0;
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (cmd_take)
                    begin
                        priority case (cmd_data.kind)
                            CMD_LIT:
                            begin
                                od_reg <= '{cmd_data.lit, 8'd0, 8'd0, 8'd0,
                                            3'd1, 1'b1, 1'b0, 1'b0};
                                wp_reg <= (cmd_data.restart ? 13'd0 : wp_reg) + 13'd1;
                                prod_reg <= (prod_eff[WIN_BITS]) ? prod_eff
                                            : prod_eff + 14'd1;
                            end
                            CMD_END:
                            begin
                                od_reg <= '{8'd0, 8'd0, 8'd0, 8'd0, 3'd0, 1'b1, 1'b1, 1'b0};
                                if (cmd_data.restart)
                                begin
                                    wp_reg <= '0;
                                    prod_reg <= '0;
                                end
                            end
                            default:
                            begin
                                if (cmd_data.restart)
                                begin
                                    wp_reg <= '0;
                                    prod_reg <= '0;
                                end
                                dist_reg <= cmd_data.offset;
                                err_reg <= back > prod_eff;
                                rem_reg <= (cmd_data.len > 9'd256) ? 9'd256 : cmd_data.len;
                                idx_reg <= '0;
                                pack_reg <= '0;
                                state_reg <= ST_READ;
                            end
                        endcase
                    end
                end
                ST_READ:
                    state_reg <= ST_WRITE;
                default:
                begin
                    if (wen)
                    begin
                        wp_reg <= wp_reg + 13'd1;
                        prod_reg <= prod_reg[WIN_BITS] ? prod_reg : prod_reg + 14'd1;
                        rem_reg <= rem_reg - 9'd1;
                        idx_reg <= idx_reg + 2'd1;
                        if (flush)
                        begin
                            od_reg.out_byte0 <= (idx_reg == 2'd0) ? wbyte : pack_reg[7:0];
                            od_reg.out_byte1 <= (idx_reg == 2'd1) ? wbyte
                                : (idx_reg > 2'd1 ? pack_reg[15:8] : 8'd0);
                            od_reg.out_byte2 <= (idx_reg == 2'd2) ? wbyte
                                : (idx_reg > 2'd2 ? pack_reg[23:16] : 8'd0);
                            od_reg.out_byte3 <= (idx_reg == 2'd3) ? wbyte : 8'd0;
                            od_reg.byte_count <= {1'b0, idx_reg} + 3'd1;
                            od_reg.last <= (rem_reg == 9'd1);
                            od_reg.end_of_data <= 1'b0;
                            od_reg.status <= err_reg;
                            pack_reg <= '0;
                        end
                        else
                            pack_reg[8*idx_reg +: 8] <= wbyte;
                        state_reg <= (rem_reg == 9'd1) ? ST_IDLE : ST_READ;
                    end
                end
            endcase
        end
    end

endmodule

>>> rtl/lz_window_bitflag_decompressor.sv
// LZEXE-style decompressor: takes one compressed byte per request and returns results of up
// to four bytes each. A parser decodes flag words and tokens at one byte per cycle unless the
// queue is full, and pushes literal, copy and end commands into a two-entry queue. The
// executor turns a literal into a result directly; a copy of up to 256 bytes does one history
// read and one write per byte on the 8 KiB history RAM, alternating read and write steps.
// There is no clearing pass: history validity follows the produced count.
module lz_window_bitflag_decompressor (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    input  lzd_pkg::lzd_in_t  in_data,
    output logic              out_valid,
    input  logic              out_stall,
    output lzd_pkg::lzd_out_t out_data
);
    import lzd_pkg::*;

    logic     pc_valid, pc_stall;
    lzd_cmd_t pc_data;
    logic     qe_valid, qe_take;
    lzd_cmd_t qe_data;

    // Front end: byte parser.
    lzd_parser u_parser (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
        .cmd_valid(pc_valid), .cmd_stall(pc_stall), .cmd_data(pc_data)
    );

    // Command queue.
    lzd_queue u_queue (
        .clk(clk), .rst_n(rst_n),
        .wr_valid(pc_valid), .wr_stall(pc_stall), .wr_data(pc_data),
        .rd_valid(qe_valid), .rd_take(qe_take), .rd_data(qe_data)
    );

    // Back end: history and output packing.
    lzd_exec u_exec (
        .clk(clk), .rst_n(rst_n),
        .cmd_valid(qe_valid), .cmd_take(qe_take), .cmd_data(qe_data),
        .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
    );

endmodule

>>> rtl/lzd_checker.sv
module lzd_checker (
    input logic              clk,
    input logic              rst_n,
    input logic              out_valid,
    input logic              out_stall,
    input lzd_pkg::lzd_out_t out_data
);
    import lzd_pkg::*;

    // A result never carries more than four bytes.
    a_count: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> out_data.byte_count <= 3'd4)
        else $error("byte_count out of range");

    // The end marker result is a lone empty last result.
    a_end: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.end_of_data |-> out_data.last && out_data.byte_count == 3'd0)
        else $error("bad end marker result");

    // Bytes of a failed copy are zero; only the first byte is checked.
    a_err: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.status |-> out_data.out_byte0 == 8'd0)
        else $error("failed copy carries data");

    // A stalled result holds.
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(out_data))
        else $error("stalled result changed");

endmodule

bind lz_window_bitflag_decompressor lzd_checker u_lzd_checker (
    .clk(clk), .rst_n(rst_n), .out_valid(out_valid), .out_stall(out_stall),
    .out_data(out_data)
);
